// File: src/crcfr_pkg.sv
// Shared types and constants for the CRC-checked frame receiver.
// Holds payload structs, phase and result codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package crcfr_pkg;

  // Default width of the payload length the block accepts
  localparam int LENGTH_BITS_DEFAULT = 24;

  localparam int REG_DATA_W = 24;
  localparam int FRAME_LEN_W = 24;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Header byte positions after the magic pair
  localparam int HDR_LEN_FIRST = 2;
  localparam int HDR_CRC_LO = 6;
  localparam int HDR_CRC_HI = 7;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0] MAGIC_FIRST_RST = 8'hAA;
  localparam logic [7:0] MAGIC_SECOND_RST = 8'h55;
  localparam logic [23:0] MAX_LENGTH_RST = 24'd65536;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  typedef enum logic [1:0] {
    REG_MAGIC_FIRST = 2'd0,
    REG_MAGIC_SECOND = 2'd1,
    REG_MAX_LENGTH = 2'd2,
    REG_TIMEOUT_TICKS = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HEADER = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CRC = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_GOOD = 3'd2,
    KIND_HDR_BAD = 3'd3,
    KIND_CRC_BAD = 3'd4,
    KIND_TIMEOUT = 3'd5
  } kind_t;

  typedef struct packed {
    logic cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_t kind;
    logic [7:0] payload_byte;
    logic [FRAME_LEN_W-1:0] frame_length;
  } out_item_t;

endpackage

`default_nettype wire

// File: src/crcfr_crc_byte.sv
// Byte-wide CRC-16 update, polynomial 0x1021, MSB first.
// Depends on crcfr_pkg for the polynomial.
`default_nettype none

module crcfr_crc_byte (
  input  wire logic [15:0] crc,
  input  wire logic [7:0]  data,
  output logic [15:0]      crc_next
);
  import crcfr_pkg::*;

  always_comb begin
    logic [15:0] acc;
    acc = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    crc_next = acc;
  end

endmodule

`default_nettype wire

// File: src/crcfr_skid.sv
// Two-entry output buffer for result transactions.
// Lets a new result enter while the previous one still waits. Depends on crcfr_pkg.
`default_nettype none

module crcfr_skid (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      push_ready,
  input  wire crcfr_pkg::out_item_t push_item,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output crcfr_pkg::out_item_t      pop_item
);
  import crcfr_pkg::*;

  logic main_valid;
  logic spare_valid;
  out_item_t main_item;
  out_item_t spare_item;
  logic take;
  logic drain;

  assign push_ready = !spare_valid;
  assign pop_valid = main_valid;
  assign pop_item = main_item;
  assign take = push && !spare_valid;
  assign drain = main_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      spare_valid <= 1'b0;
    end else if (drain) begin
      if (spare_valid) begin
        main_valid <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        main_valid <= take;
      end
    end else if (take) begin
      if (main_valid) begin
        spare_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      main_item <= spare_valid ? spare_item : push_item;
    end else if (take && !main_valid) begin
      main_item <= push_item;
    end
    if (take && main_valid && !drain) begin
      spare_item <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: src/crc_checked_frame_receiver.sv
// Receiver for length-prefixed frames checked with CRC-16/CCITT-FALSE. Each input
// transaction is a received byte or a millisecond tick, and each one yields exactly one
// result transaction (kind none, payload byte, frame good, header rejected, payload CRC
// bad or timeout). A frame is two magic bytes, a 32-bit little-endian length, a
// little-endian header CRC over the first six bytes, the payload and a little-endian
// payload CRC. The block takes one transaction per clock while item_ready is high: the
// whole state update, including the byte-wide CRC step, is combinational, and the result
// is registered into a two-entry output buffer in the cycle after acceptance, so item_ready only drops when
// two results wait. Configuration writes take effect at once and belong between frames.
// Depends on crcfr_pkg, crcfr_crc_byte and crcfr_skid.
`default_nettype none

module crc_checked_frame_receiver #(
  parameter int LENGTH_BITS = crcfr_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire crcfr_pkg::in_item_t               item,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output crcfr_pkg::out_item_t                   result,
  input  wire logic                              cfg_we,
  input  wire crcfr_pkg::cfg_reg_t               cfg_index,
  input  wire logic [crcfr_pkg::REG_DATA_W-1:0]  cfg_data
);
  import crcfr_pkg::*;

  localparam int CNT_W = LENGTH_BITS + 1;
  localparam logic [31:0] LEN_MASK =
    (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << LENGTH_BITS) - 32'd1);

  // Configuration registers
  logic [7:0] magic_first;
  logic [7:0] magic_second;
  logic [23:0] max_length;
  logic [15:0] timeout_ticks;

  // Frame state
  phase_t phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [LENGTH_BITS-1:0] expected_length, expected_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [31:0] header_length_shift, header_length_shift_next;
  logic [7:0] received_crc_low, received_crc_low_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  logic accept;
  logic [15:0] crc_seed;
  logic [15:0] crc_upd;
  logic restart;
  logic [15:0] got_crc;
  logic [CNT_W-1:0] count_inc;
  logic [31:0] exp_wide;
  out_item_t res;

  assign accept = item_valid && item_ready;
  assign got_crc = {item.rx_byte, received_crc_low};
  assign count_inc = byte_count + CNT_W'(1);
  assign exp_wide = 32'(expected_length);

  // Any wrong second byte reseeds the CRC; one that matches the first magic restarts the CRC from its seed
  assign restart = (phase == PH_HEADER) && (byte_count == CNT_W'(1)) &&
                   (item.rx_byte != magic_second);
  assign crc_seed = restart ? CRC_INIT : running_crc;

  crcfr_crc_byte u_crc (
    .crc      (crc_seed),
    .data     (item.rx_byte),
    .crc_next (crc_upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first <= MAGIC_FIRST_RST;
      magic_second <= MAGIC_SECOND_RST;
      max_length <= MAX_LENGTH_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAGIC_FIRST: magic_first <= cfg_data[7:0];
        REG_MAGIC_SECOND: magic_second <= cfg_data[7:0];
        REG_MAX_LENGTH: max_length <= cfg_data[23:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic go_idle;
    logic hunt;
    logic [31:0] len;
    go_idle = 1'b0;
    hunt = 1'b0;
    len = header_length_shift;
    phase_next = phase;
    byte_count_next = byte_count;
    expected_length_next = expected_length;
    running_crc_next = running_crc;
    header_length_shift_next = header_length_shift;
    received_crc_low_next = received_crc_low;
    idle_ticks_next = idle_ticks;
    res.kind = KIND_NONE;
    res.payload_byte = 8'h00;
    res.frame_length = '0;

    if (item.cmd == CMD_TICK) begin
      if (phase != PH_IDLE) begin
        if (idle_ticks >= timeout_ticks) begin
          res.kind = KIND_TIMEOUT;
          go_idle = 1'b1;
        end else begin
          idle_ticks_next = idle_ticks + 16'd1;
        end
      end
    end else begin
      idle_ticks_next = '0;
      case (phase)
        PH_IDLE: begin
          hunt = (item.rx_byte == magic_first);
        end
        PH_HEADER: begin
          if (byte_count == CNT_W'(1)) begin
            if (restart) begin
              go_idle = 1'b1;
              hunt = (item.rx_byte == magic_first);
            end else begin
              running_crc_next = crc_upd;
              byte_count_next = CNT_W'(HDR_LEN_FIRST);
            end
          end else if (byte_count < CNT_W'(HDR_CRC_LO)) begin
            // Length arrives low byte first: shift in from the top
            header_length_shift_next = {item.rx_byte, header_length_shift[31:8]};
            running_crc_next = crc_upd;
            byte_count_next = count_inc;
          end else if (byte_count == CNT_W'(HDR_CRC_LO)) begin
            received_crc_low_next = item.rx_byte;
            byte_count_next = CNT_W'(HDR_CRC_HI);
          end else begin
            if (got_crc != running_crc || len == 32'd0 || len > 32'(max_length) ||
                (len & ~LEN_MASK) != 32'd0) begin
              res.kind = KIND_HDR_BAD;
              go_idle = 1'b1;
            end else begin
              expected_length_next = len[LENGTH_BITS-1:0];
              phase_next = PH_PAYLOAD;
              byte_count_next = '0;
              running_crc_next = CRC_INIT;
            end
          end
        end
        PH_PAYLOAD: begin
          res.kind = KIND_PAYLOAD;
          res.payload_byte = item.rx_byte;
          running_crc_next = crc_upd;
          byte_count_next = count_inc;
          if (count_inc >= {1'b0, expected_length}) begin
            phase_next = PH_CRC;
            byte_count_next = '0;
          end
        end
        PH_CRC: begin
          if (byte_count == '0) begin
            received_crc_low_next = item.rx_byte;
            byte_count_next = CNT_W'(1);
          end else begin
            if (got_crc == running_crc) begin
              res.kind = KIND_GOOD;
              res.frame_length = exp_wide[FRAME_LEN_W-1:0];
            end else begin
              res.kind = KIND_CRC_BAD;
            end
            go_idle = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase
    end

    if (go_idle || hunt) begin
      phase_next = PH_IDLE;
      byte_count_next = '0;
      expected_length_next = '0;
      running_crc_next = CRC_INIT;
      header_length_shift_next = '0;
      received_crc_low_next = '0;
      idle_ticks_next = '0;
    end
    if (hunt) begin
      phase_next = PH_HEADER;
      byte_count_next = CNT_W'(1);
      running_crc_next = crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      byte_count <= '0;
      expected_length <= '0;
      running_crc <= CRC_INIT;
      header_length_shift <= '0;
      received_crc_low <= '0;
      idle_ticks <= '0;
    end else if (accept) begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      expected_length <= expected_length_next;
      running_crc <= running_crc_next;
      header_length_shift <= header_length_shift_next;
      received_crc_low <= received_crc_low_next;
      idle_ticks <= idle_ticks_next;
    end
  end

  crcfr_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_ready (item_ready),
    .push_item  (res),
    .pop_valid  (result_valid),
    .pop_ready  (result_ready),
    .pop_item   (result)
  );

endmodule

`default_nettype wire

// File: src/crcfr_checker.sv
// Port-level checks for crc_checked_frame_receiver, attached by the bind below.
// Depends on crcfr_pkg and the top level's port list.
`default_nettype none

module crcfr_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 item_valid,
  input wire logic                 item_ready,
  input wire logic                 result_valid,
  input wire logic                 result_ready,
  input wire crcfr_pkg::out_item_t result
);
  import crcfr_pkg::*;

  // A stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Input back-pressure only when a result is already waiting
  a_ready_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid)
    else $error("input stalled with an empty output buffer");

  // An accepted transaction always leaves a result valid in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> result_valid)
    else $error("accepted transaction produced no result");

  // Payload byte only on payload results, length only on good frames
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.kind == KIND_PAYLOAD || result.payload_byte == 8'h00) &&
                     (result.kind == KIND_GOOD || result.frame_length == '0))
    else $error("result field set for wrong kind");

endmodule

bind crc_checked_frame_receiver crcfr_checker u_crcfr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire
